// ===== hw/rtl/fom_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fom_pkg
// Types, codes and fixed widths shared by the frame over-trigger monitor.
// ----------------------------------------------------------------------------
package fom_pkg;

  // Field widths fixed by the event format
  localparam int TIME_W   = 32;
  localparam int SUM_T_W  = 33;  // image time plus sample time
  localparam int FRAME_W  = 31;
  localparam int PERIOD_W = 20;
  localparam int TOL_W    = 20;
  localparam int WAIT_W   = 40;
  localparam int RUN_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  // Time split into microseconds and leftover nanoseconds
  localparam int Q_W = 24;  // floor of a 33-bit time over 1000
  localparam int R_W = 10;  // remainder below 1000

  // Divide by 1000: shift right by 3, then multiply by ceil(2^37 / 125)
  localparam int DIV_X_W = SUM_T_W - 3;
  localparam int DIV_M_W = 31;
  localparam int DIV_SHIFT = 37;
  localparam int PROD_W = DIV_X_W + DIV_M_W + 1;
  localparam logic [DIV_M_W-1:0] DIV_MULT = 31'd1099511628;

  // Thresholds and limits
  localparam int MS_NS        = 1000;  // ns per us, also per-mille full scale
  localparam int CRIT_PERMIL  = 950;
  localparam int DANGER_PERMIL = 900;
  localparam int HARD_FACTOR  = 3;
  localparam int EARLY_FRAMES = 5;
  localparam int RUN_LIMIT    = 5;
  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;

  typedef enum logic [2:0] {
    OP_PROC  = 3'd0,
    OP_SKIP  = 3'd1,
    OP_WAIT  = 3'd2,
    OP_CHECK = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DANGER = 2'd1,
    ST_CRIT   = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [TIME_W-1:0]  first_time_ns;
    logic [TIME_W-1:0]  second_time_ns;
    logic               new_frame;
    logic [FRAME_W-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic             status_valid;
    logic [1:0]       status;
    logic [RUN_W-1:0] overrun_run;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TOL_W-1:0]    tol;
    logic                mode;
  } cfg_t;

  // Event after the divider: time split into us and ns remainder
  typedef struct packed {
    logic [2:0]         op;
    logic [SUM_T_W-1:0] t;
    logic [Q_W-1:0]     q;
    logic [R_W-1:0]     r;
    logic               new_frame;
    logic               early;
  } div_item_t;

  // Kind of event travelling down the check pipeline
  typedef struct packed {
    logic is_check;
    logic early;
  } chk_ctl_t;

endpackage : fom_pkg
`default_nettype wire

// ===== hw/rtl/fom_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fom_divider
// Three-stage split of frame time into us and ns: input, product, quotient.
// ----------------------------------------------------------------------------
module fom_divider
  import fom_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output div_item_t      out_item_o
);

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  div_item_t         s1_d, s1_q, s2_q, s3_d, s3_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [R_W+23:0]   qk;
  logic [R_W+23:0]   rem_full;

  // Stage readiness: a stage takes data when empty or when it drains
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Form the frame time and the early-frame flag
  always_comb begin
    s1_d           = '0;
    s1_d.op        = in_item_i.operation;
    s1_d.t         = {1'b0, in_item_i.first_time_ns}
                   + ((in_item_i.operation == OP_PROC) ?
                      {1'b0, in_item_i.second_time_ns} : {SUM_T_W{1'b0}});
    s1_d.new_frame = in_item_i.new_frame;
    s1_d.early     = (in_item_i.frame_number <= FRAME_W'(EARLY_FRAMES));
  end

  // Reciprocal product for the divide by 1000
  assign prod_d = PROD_W'(s1_q.t[SUM_T_W-1:3]) * PROD_W'(DIV_MULT);

  // Quotient from the product, remainder by back-multiply
  always_comb begin
    s3_d     = s2_q;
    s3_d.q   = prod_q[DIV_SHIFT+Q_W-1:DIV_SHIFT];
    qk       = (R_W+24)'(s3_d.q) * (R_W+24)'(MS_NS);
    rem_full = (R_W+24)'(s2_q.t) - qk;
    s3_d.r   = rem_full[R_W-1:0];
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Move payloads on each transfer
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q) begin
      s2_q   <= s1_q;
      prod_q <= prod_d;
    end
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = s3_q;

endmodule : fom_divider
`default_nettype wire

// ===== hw/rtl/fom_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fom_window
// Sliding window of frame times, running sum and wait accumulation.
// ----------------------------------------------------------------------------
module fom_window
  import fom_pkg::*;
#(
  parameter int WINDOW_LEN = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire div_item_t  in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output chk_ctl_t        out_ctl_o,
  output logic [$clog2(WINDOW_LEN+1)-1:0]    out_count_o,
  output logic [WAIT_W-1:0]                  out_wait_o,
  output logic [Q_W+$clog2(WINDOW_LEN+1)-1:0] out_sumq_o
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUMQ_W = Q_W + CNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W:0]   LEN_EXT  = (CNT_W+1)'(WINDOW_LEN);
  localparam logic signed [R_W+1:0] RMOD_S = (R_W+2)'(MS_NS);

  logic [Q_W-1:0]    ent_q_q [WINDOW_LEN];
  logic [R_W-1:0]    ent_r_q [WINDOW_LEN];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  head_q, head_d, wr_idx;
  logic [SUMQ_W-1:0] sumq_q, sumq_d;
  logic [R_W-1:0]    sumr_q, sumr_d;
  logic [WAIT_W-1:0] latched_q, latched_d, partial_q, partial_d;

  logic              xfer, full, push;
  logic [Q_W-1:0]    old_q;
  logic [R_W-1:0]    old_r;
  logic [CNT_W:0]    wr_sum;
  logic signed [R_W+1:0] rsum, rnorm;
  logic              carry, borrow;
  logic [SUMQ_W-1:0] push_sumq;
  logic [WAIT_W-1:0] t_ext;

  logic              ov_q;
  chk_ctl_t          ctl_q;
  logic [CNT_W-1:0]  n_q;
  logic [WAIT_W-1:0] wait_q;
  logic [SUMQ_W-1:0] osumq_q;

  function automatic logic [WAIT_W-1:0] sat_add(logic [WAIT_W-1:0] a,
                                                logic [WAIT_W-1:0] b);
    logic [WAIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WAIT_W] ? {WAIT_W{1'b1}} : s[WAIT_W-1:0];
  endfunction

  assign in_ready_o = !ov_q || out_ready_i;
  assign xfer = in_valid_i && in_ready_o;
  assign push = (in_item_i.op == OP_PROC) || (in_item_i.op == OP_SKIP);

  // Locate the entry to write and the one that leaves
  always_comb begin
    full   = (count_q == FULL_CNT);
    old_q  = full ? ent_q_q[head_q] : '0;
    old_r  = full ? ent_r_q[head_q] : '0;
    wr_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
    if (full) begin
      wr_idx = head_q;
    end else if (wr_sum >= LEN_EXT) begin
      wr_idx = IDX_W'(wr_sum - LEN_EXT);
    end else begin
      wr_idx = IDX_W'(wr_sum);
    end
  end

  // Update the running sum as us count plus ns remainder
  always_comb begin
    rsum   = $signed({2'b00, sumr_q}) + $signed({2'b00, in_item_i.r})
           - $signed({2'b00, old_r});
    borrow = (rsum < 0);
    carry  = (rsum >= RMOD_S);
    if (borrow) begin
      rnorm = rsum + RMOD_S;
    end else if (carry) begin
      rnorm = rsum - RMOD_S;
    end else begin
      rnorm = rsum;
    end
    push_sumq = sumq_q + SUMQ_W'(in_item_i.q) - SUMQ_W'(old_q)
              + SUMQ_W'(carry) - SUMQ_W'(borrow);
  end

  assign t_ext = WAIT_W'(in_item_i.t);

  // Next window and wait state for the event
  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    sumq_d    = sumq_q;
    sumr_d    = sumr_q;
    latched_d = latched_q;
    partial_d = partial_q;
    case (in_item_i.op)
      OP_PROC, OP_SKIP: begin
        sumq_d = push_sumq;
        sumr_d = rnorm[R_W-1:0];
        if (full) begin
          head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      OP_WAIT: begin
        if (in_item_i.new_frame) begin
          latched_d = sat_add(t_ext, partial_q);
          partial_d = '0;
        end else begin
          partial_d = sat_add(partial_q, t_ext);
        end
      end
      OP_CLEAR: begin
        count_d   = '0;
        head_d    = '0;
        sumq_d    = '0;
        sumr_d    = '0;
        latched_d = '0;
        partial_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      head_q    <= '0;
      sumq_q    <= '0;
      sumr_q    <= '0;
      latched_q <= '0;
      partial_q <= '0;
    end else if (xfer) begin
      count_q   <= count_d;
      head_q    <= head_d;
      sumq_q    <= sumq_d;
      sumr_q    <= sumr_d;
      latched_q <= latched_d;
      partial_q <= partial_d;
    end
  end

  // Write a pushed time into the window
  always_ff @(posedge clk_i) begin
    if (xfer && push) begin
      ent_q_q[wr_idx] <= in_item_i.q;
      ent_r_q[wr_idx] <= in_item_i.r;
    end
  end

  // Register the state snapshot that a check needs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (in_ready_o) begin
      ov_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      ctl_q.is_check <= (in_item_i.op == OP_CHECK);
      ctl_q.early    <= in_item_i.early;
      n_q            <= count_q;
      wait_q         <= latched_q;
      osumq_q        <= sumq_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_ctl_o   = ctl_q;
  assign out_count_o = n_q;
  assign out_wait_o  = wait_q;
  assign out_sumq_o  = osumq_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("window count above window length");

  a_empty_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sumq_q == '0) && (sumr_q == '0))
    else $error("empty window with nonzero sum");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && push && !full) |=> (count_q != '0))
    else $error("push into window left it empty");
`endif

endmodule : fom_window
`default_nettype wire

// ===== hw/rtl/fom_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fom_check
// Threshold pipeline, over-run counter and result register.
// ----------------------------------------------------------------------------
module fom_check
  import fom_pkg::*;
#(
  parameter int WINDOW_LEN = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire chk_ctl_t  in_ctl_i,
  input  wire logic [$clog2(WINDOW_LEN+1)-1:0]     in_count_i,
  input  wire logic [WAIT_W-1:0]                   in_wait_i,
  input  wire logic [Q_W+$clog2(WINDOW_LEN+1)-1:0] in_sumq_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUMQ_W = Q_W + CNT_W;
  localparam int NL_W   = WAIT_W + CNT_W;
  localparam int PN_W   = PERIOD_W + CNT_W;
  localparam int A_W    = NL_W + 1;
  localparam int T_W    = PN_W + $clog2(WINDOW_LEN + 1) + 1;
  localparam int H_W    = PN_W + $clog2(HARD_FACTOR * WINDOW_LEN + 1) + 1;
  localparam int CMP_W  = (A_W > H_W + R_W) ? A_W : H_W + R_W;
  localparam int CONS_FACTOR = (WINDOW_LEN > 1) ? WINDOW_LEN - 1 : 1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  chk_ctl_t          ctl1_q, ctl2_q, ctl3_q;
  logic [NL_W-1:0]   nl_q;
  logic [PN_W-1:0]   pn_q;
  logic [SUMQ_W-1:0] sumq1_q;
  logic [A_W-1:0]    a_d, a_q;
  logic [T_W-1:0]    t_d, t_q;
  logic [H_W-1:0]    h_d, h_q;
  logic [H_W-1:0]    tol_extra;
  logic              over_d, o950_d, o900_d, oh_d;
  logic              over_q, o950_q, o900_q, oh_q;

  logic [RUN_W-1:0]  run_q, run_inc, run_next;
  logic              late, adv4, late_q;
  status_e           st;
  out_item_t         out_d, out_q;

  // Stage readiness
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Measured work, allowed budget and hard limit
  always_comb begin
    a_d = A_W'(nl_q) + A_W'(sumq1_q) * A_W'(MS_NS);
    if (cfg_i.mode) begin
      t_d = T_W'(pn_q) * T_W'(CONS_FACTOR);
    end else begin
      t_d = T_W'(pn_q) * T_W'(WINDOW_LEN) + T_W'(cfg_i.tol);
    end
    tol_extra = (cfg_i.tol > TOL_W'(MS_NS)) ? H_W'(cfg_i.tol - TOL_W'(MS_NS)) : '0;
    h_d = H_W'(pn_q) * H_W'(HARD_FACTOR * WINDOW_LEN) + tol_extra;
  end

  // Compare against the scaled thresholds
  always_comb begin
    over_d = CMP_W'(a_q) > CMP_W'(t_q) * CMP_W'(MS_NS);
    o950_d = CMP_W'(a_q) > CMP_W'(t_q) * CMP_W'(CRIT_PERMIL);
    o900_d = CMP_W'(a_q) > CMP_W'(t_q) * CMP_W'(DANGER_PERMIL);
    oh_d   = CMP_W'(a_q) > CMP_W'(h_q) * CMP_W'(MS_NS);
  end

  // Advance the over-run counter and grade the check
  always_comb begin
    late    = ctl3_q.is_check && !ctl3_q.early;
    adv4    = v3_q && rdy4;
    run_inc = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
    run_next = late ? (over_q ? run_inc : '0) : run_q;
    if ((run_next > RUN_W'(RUN_LIMIT)) || oh_q) begin
      st = ST_OVER;
    end else if ((run_next != '0) || o950_q) begin
      st = ST_CRIT;
    end else if (o900_q) begin
      st = ST_DANGER;
    end else begin
      st = ST_OK;
    end
    out_d.status_valid = ctl3_q.is_check;
    out_d.status       = late ? st : ST_OK;
    out_d.overrun_run  = run_next;
  end

  // Advance stage valids and the counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      run_q <= '0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (adv4) run_q <= run_next;
    end
  end

  // Move payloads on each transfer
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ctl1_q  <= in_ctl_i;
      nl_q    <= NL_W'(in_wait_i) * NL_W'(in_count_i);
      pn_q    <= PN_W'(cfg_i.period) * PN_W'(in_count_i);
      sumq1_q <= in_sumq_i;
    end
    if (rdy2 && v1_q) begin
      ctl2_q <= ctl1_q;
      a_q    <= a_d;
      t_q    <= t_d;
      h_q    <= h_d;
    end
    if (rdy3 && v2_q) begin
      ctl3_q <= ctl2_q;
      over_q <= over_d;
      o950_q <= o950_d;
      o900_q <= o900_d;
      oh_q   <= oh_d;
    end
    if (adv4) begin
      out_q  <= out_d;
      late_q <= late;
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_run_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv4 && late) |=> $stable(run_q))
    else $error("over-run counter moved without a graded check");

  a_run_crit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && late_q && (out_q.overrun_run != '0))
      |-> (out_q.status == ST_CRIT) || (out_q.status == ST_OVER))
    else $error("active over-run graded below critical");

  a_thr_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (!over_q || o950_q) && (!o950_q || o900_q))
    else $error("threshold flags out of order");
`endif

endmodule : fom_check
`default_nettype wire

// ===== hw/rtl/frame_overtrigger_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_overtrigger_monitor
// Frame-time watchdog: sliding window of frame times against trigger period.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in channel (valid/ready, in_item_i). Each accepted
//   event gives exactly one result on the out channel (valid/ready,
//   out_item_o); only check events set status_valid.
//   Configuration registers (period, tolerance, mode) are written through the
//   cfg channel, which is always ready; write them only while no event is in
//   flight.
//   Pipeline: 3 divider stages, 1 window stage, 4 check stages ending in the
//   result register.
//   Throughput: one event per cycle while the receiver takes results; the
//   window and the over-run counter keep pace with back-to-back events.
//   Reset empties the window and waits, clears the over-run counter and
//   loads the period with 1000 us, tolerance 0, normal mode.
//   When the receiver stalls, the result register holds and the stages
//   behind it keep filling their empty slots; input ready drops only once
//   every stage holds an event.
// ----------------------------------------------------------------------------
module frame_overtrigger_monitor
  import fom_pkg::*;
#(
  parameter int WINDOW_LEN = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUMQ_W = Q_W + CNT_W;

  cfg_t              cfg_q;
  logic              div_valid, div_ready;
  div_item_t         div_item;
  logic              win_valid, win_ready;
  chk_ctl_t          win_ctl;
  logic [CNT_W-1:0]  win_count;
  logic [WAIT_W-1:0] win_wait;
  logic [SUMQ_W-1:0] win_sumq;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PERIOD_RESET;
      cfg_q.tol    <= '0;
      cfg_q.mode   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PERIOD: cfg_q.period <= cfg_data_i[PERIOD_W-1:0];
        CFG_TOL:    cfg_q.tol    <= cfg_data_i[TOL_W-1:0];
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  fom_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_item_o  (div_item)
  );

  fom_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_item_i   (div_item),
    .out_valid_o (win_valid),
    .out_ready_i (win_ready),
    .out_ctl_o   (win_ctl),
    .out_count_o (win_count),
    .out_wait_o  (win_wait),
    .out_sumq_o  (win_sumq)
  );

  fom_check #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .in_ctl_i    (win_ctl),
    .in_count_i  (win_count),
    .in_wait_i   (win_wait),
    .in_sumq_i   (win_sumq),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule : frame_overtrigger_monitor
`default_nettype wire

// ===== tb/tb_frame_overtrigger_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_overtrigger_monitor
// Self-checking bench for the frame over-trigger monitor. A scoreboard class
// keeps its own copy of the frame-time window, the waits, the over-run
// counter and the registers, predicts one result per accepted event and
// compares each result field by field. Stimulus runs a directed set of edge
// cases, then random frame sequences under several register settings with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_frame_overtrigger_monitor;
  import fom_pkg::*;

  typedef longint unsigned u64_t;

  localparam int          WIN_LEN      = 4;
  localparam u64_t        CONS_FACTOR  = (WIN_LEN > 1) ? WIN_LEN - 1 : 1;
  localparam u64_t        NS_PER_US    = 1000;
  localparam u64_t        PERMIL       = 1000;
  localparam u64_t        CRIT_MIL     = 950;
  localparam u64_t        DANGER_MIL   = 900;
  localparam u64_t        HARD_MULT    = 3;
  localparam u64_t        HARD_TOL_OFS = 1000;
  localparam u64_t        WAIT_SAT     = 64'hFF_FFFF_FFFF;
  localparam int unsigned EARLY_LAST   = 5;
  localparam int unsigned RUN_HIGH     = 5;
  localparam int unsigned RUN_SAT      = 255;
  localparam logic [2:0]  OP_LAST_CODE = 3'd7;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: window, waits and over-run counter tracked per event
  // --------------------------------------------------------------------------
  class overtrigger_scoreboard;
    logic [PERIOD_W-1:0] period_us;
    logic [TOL_W-1:0]    tol_us;
    logic                cons_mode;
    logic [SUM_T_W-1:0]  win_times [WIN_LEN];
    int unsigned         win_head;
    int unsigned         win_count;
    u64_t                win_sum;
    u64_t                latched_ns;
    u64_t                partial_ns;
    int unsigned         run_cnt;
    out_item_t           status_due_q[$];
    int unsigned         errors;

    function new();
      period_us  = PERIOD_RESET;
      tol_us     = '0;
      cons_mode  = 1'b0;
      win_head   = 0;
      win_count  = 0;
      win_sum    = 0;
      latched_ns = 0;
      partial_ns = 0;
      run_cnt    = 0;
      errors     = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PERIOD: period_us = val;
        CFG_TOL:    tol_us    = val;
        CFG_MODE:   cons_mode = val[0];
        default:    ;
      endcase
    endfunction

    function u64_t sat_wait(u64_t v);
      return (v > WAIT_SAT) ? WAIT_SAT : v;
    endfunction

    // Replace the oldest entry once the window is full
    function void push_time(u64_t t);
      if (win_count >= WIN_LEN) begin
        win_sum -= win_times[win_head];
        win_times[win_head] = t;
        win_head = (win_head + 1) % WIN_LEN;
      end else begin
        win_times[(win_head + win_count) % WIN_LEN] = t;
        win_count++;
      end
      win_sum += t;
    endfunction

    function status_e predict_check(logic [FRAME_W-1:0] frame);
      u64_t n, acc, lim, hard;
      n = win_count;
      if (frame <= EARLY_LAST) return ST_OK;
      acc = n * latched_ns + NS_PER_US * (win_sum / NS_PER_US);
      if (cons_mode) lim = u64_t'(period_us) * n * CONS_FACTOR;
      else lim = u64_t'(period_us) * n * WIN_LEN + tol_us;
      hard = HARD_MULT * u64_t'(period_us) * n * WIN_LEN
             + ((u64_t'(tol_us) > HARD_TOL_OFS) ? u64_t'(tol_us) - HARD_TOL_OFS : 0);
      // Advance or drop the over-run counter
      if (acc > PERMIL * lim) begin
        if (run_cnt < RUN_SAT) run_cnt++;
      end else begin
        run_cnt = 0;
      end
      if (run_cnt > RUN_HIGH || acc > PERMIL * hard) return ST_OVER;
      if (run_cnt > 0 || acc > CRIT_MIL * lim) return ST_CRIT;
      if (acc > DANGER_MIL * lim) return ST_DANGER;
      return ST_OK;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t due;
      due = '0;
      case (ev.operation)
        OP_PROC: push_time(u64_t'(ev.first_time_ns) + u64_t'(ev.second_time_ns));
        OP_SKIP: push_time(u64_t'(ev.first_time_ns));
        OP_WAIT: begin
          if (ev.new_frame) begin
            latched_ns = sat_wait(partial_ns + ev.first_time_ns);
            partial_ns = 0;
          end else begin
            partial_ns = sat_wait(partial_ns + ev.first_time_ns);
          end
        end
        OP_CHECK: begin
          due.status_valid = 1'b1;
          due.status       = predict_check(ev.frame_number);
        end
        OP_CLEAR: begin
          win_count  = 0;
          win_head   = 0;
          win_sum    = 0;
          latched_ns = 0;
          partial_ns = 0;
        end
        default: ;
      endcase
      due.overrun_run = RUN_W'(run_cnt);
      status_due_q.push_back(due);
    endfunction

    function void check_status(out_item_t got);
      out_item_t due;
      if (status_due_q.size() == 0) begin
        $error("unexpected result: status_valid %0d status %0d overrun_run %0d",
               got.status_valid, got.status, got.overrun_run);
        errors++;
        return;
      end
      // Take the oldest expected result
      due = status_due_q[0];
      status_due_q.delete(0);
      if (got.status_valid !== due.status_valid) begin
        $error("status_valid: expected %0d, got %0d", due.status_valid, got.status_valid);
        errors++;
      end
      if (got.status !== due.status) begin
        $error("status: expected %0d, got %0d", due.status, got.status);
        errors++;
      end
      if (got.overrun_run !== due.overrun_run) begin
        $error("overrun_run: expected %0d, got %0d", due.overrun_run, got.overrun_run);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return status_due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_item   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  out_item_t             out_item_o;
  logic                  cfg_ready_o;

  int unsigned           hold_req  = 0;
  logic                  no_idle   = 1'b0;
  int unsigned           sent      = 0;
  int unsigned           frame_no  = 0;
  overtrigger_scoreboard sb        = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_overtrigger_monitor #(
    .WINDOW_LEN (WIN_LEN)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Event helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_event(logic [2:0] op, logic [TIME_W-1:0] t1,
                                          logic [TIME_W-1:0] t2, logic nf,
                                          logic [FRAME_W-1:0] frame);
    in_item_t ev;
    ev.operation      = op;
    ev.first_time_ns  = t1;
    ev.second_time_ns = t2;
    ev.new_frame      = nf;
    ev.frame_number   = frame;
    return ev;
  endfunction

  function automatic logic [TIME_W-1:0] clamp32(u64_t v);
    return (v > u64_t'(32'hFFFF_FFFF)) ? '1 : v[TIME_W-1:0];
  endfunction

  // Offer one event, with an occasional idle burst ahead of it
  task automatic send_event(input in_item_t ev);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (!in_ready_o);
    sb.note_event(ev);
    sent++;
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    sb.load_reg(idx, val);
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] period,
                            input logic [TOL_W-1:0] tol, input logic mode);
    drain();
    cfg_write(CFG_PERIOD, period);
    cfg_write(CFG_TOL, tol);
    cfg_write(CFG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    cfg_valid <= 1'b0;
  endtask

  // One frame: partial waits, latched wait, frame time, check. Now and then
  // a clear, a stray event, or a frame without its check.
  task automatic run_frame();
    u64_t              unit_ns, share_ns, wait_ns, img_ns, piece_ns;
    logic [TIME_W-1:0] head_t;
    int unsigned       pick, parts, ratio;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_event(make_event($urandom_range(0, OP_LAST_CODE), $urandom, $urandom,
                            $urandom_range(0, 1), $urandom));
      return;
    end
    if (pick < 9) begin
      send_event(make_event(OP_CLEAR, $urandom, $urandom, $urandom_range(0, 1), $urandom));
      frame_no = $urandom_range(0, EARLY_LAST);
      return;
    end
    // Aim each window entry near its share of the threshold
    if (sb.cons_mode) unit_ns = u64_t'(sb.period_us) * CONS_FACTOR * NS_PER_US;
    else unit_ns = (u64_t'(sb.period_us) * WIN_LEN + sb.tol_us / WIN_LEN) * NS_PER_US;
    if ($urandom_range(0, 9) == 0) ratio = $urandom_range(0, 3500);
    else ratio = $urandom_range(820, 1080);
    share_ns = unit_ns * ratio / PERMIL;
    wait_ns  = share_ns * $urandom_range(0, 60) / 100;
    img_ns   = share_ns - wait_ns;
    parts    = $urandom_range(0, 3);
    piece_ns = wait_ns / (parts + 1);
    repeat (parts)
      send_event(make_event(OP_WAIT, clamp32(piece_ns), $urandom, 1'b0, $urandom));
    send_event(make_event(OP_WAIT, clamp32(wait_ns - parts * piece_ns), $urandom, 1'b1,
                          $urandom));
    if ($urandom_range(0, 3) == 0) begin
      send_event(make_event(OP_SKIP, clamp32(img_ns), $urandom, $urandom_range(0, 1),
                            $urandom));
    end else begin
      head_t = clamp32(img_ns * $urandom_range(0, 100) / 100);
      send_event(make_event(OP_PROC, head_t, clamp32(img_ns - head_t),
                            $urandom_range(0, 1), $urandom));
    end
    if (pick >= 15) begin
      frame_no++;
      send_event(make_event(OP_CHECK, $urandom, $urandom, $urandom_range(0, 1),
                            ($urandom_range(0, 19) == 0) ? $urandom : frame_no));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: accept, check, stall in bursts or on a long hold request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid_o && out_ready) sb.check_status(out_item_o);
      stall = 0;
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req <= 0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 9);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transfer happens for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("frame_overtrigger_monitor regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(PERIOD_RESET, '0, 1'b0);

    // Empty window, early frames, unknown codes
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 6));
    send_event(make_event(OP_CHECK, '1, '1, 1'b1, 0));
    send_event(make_event(OP_CHECK, $urandom, $urandom, 1'b0, EARLY_LAST));
    send_event(make_event($urandom_range(OP_CLEAR + 1, OP_LAST_CODE), $urandom, $urandom,
                          1'b1, $urandom));
    send_event(make_event(OP_LAST_CODE, '1, '1, 1'b1, '1));
    // Largest times and waits, then a far over-run check
    send_event(make_event(OP_PROC, '1, '1, 1'b0, '0));
    send_event(make_event(OP_SKIP, '0, '1, 1'b1, '1));
    send_event(make_event(OP_WAIT, '1, '0, 1'b0, '0));
    send_event(make_event(OP_WAIT, '1, '0, 1'b1, '0));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, '1));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 6));
    // Clear keeps the counter; the next check resets it
    send_event(make_event(OP_CLEAR, '1, '1, 1'b1, '1));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 7));
    // Window sum right at the threshold (period 1000 us)
    repeat (WIN_LEN) send_event(make_event(OP_SKIP, 32'd4_000_000, '0, 1'b0, '0));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 8));
    // One ns above is dropped by the us rounding; a 1 ns wait tips it over
    send_event(make_event(OP_PROC, 32'd3_999_999, 32'd2, 1'b0, '0));
    send_event(make_event(OP_WAIT, 32'd1, '0, 1'b1, '0));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 9));
    // Between the dangerous and critical marks
    send_event(make_event(OP_CLEAR, '0, '0, 1'b0, '0));
    repeat (WIN_LEN) send_event(make_event(OP_SKIP, 32'd3_700_000, '0, 1'b0, '0));
    send_event(make_event(OP_CHECK, '0, '0, 1'b0, 10));

    // Shortest period; long receiver hold-off to fill the block
    set_config(20'd1, '0, 1'b0);
    hold_req <= LONG_HOLD;
    while (sent < 230) run_frame();

    // Period and tolerance 1000000 us, conservative, with a full drain midway
    set_config(20'd1_000_000, 20'd1_000_000, 1'b1);
    while (sent < 320) run_frame();
    drain();
    while (sent < 420) run_frame();

    set_config(20'd1_000_000, 20'd1_000_000, 1'b0);
    while (sent < 560) run_frame();

    // Saturate the waits, then hold the counter at its ceiling
    set_config($urandom_range(1, 1_000_000), $urandom_range(0, 1_000_000),
               $urandom_range(0, 1));
    repeat (257) send_event(make_event(OP_WAIT, '1, $urandom, 1'b0, $urandom));
    send_event(make_event(OP_WAIT, '1, $urandom, 1'b1, $urandom));
    send_event(make_event(OP_PROC, $urandom, $urandom, 1'b0, $urandom));
    frame_no = 100;
    repeat (262) begin
      frame_no++;
      send_event(make_event(OP_CHECK, $urandom, $urandom, $urandom_range(0, 1), frame_no));
    end
    while (sent < 1100) run_frame();

    // Last stretch without idling
    no_idle = 1'b1;
    set_config($urandom_range(1, 1_000_000), $urandom_range(0, 1_000_000),
               $urandom_range(0, 1));
    while (sent < 1230) run_frame();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("frame_overtrigger_monitor regression: pass");
    else
      $display("frame_overtrigger_monitor regression: fail");
    $finish;
  end

endmodule
